/* hdl/sorted_region_table_core_assert.svh */
// Assertion macros for the sorted region table core.
`ifndef SORTED_REGION_TABLE_CORE_ASSERT_SVH
`define SORTED_REGION_TABLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srt assertion failed");

// next-cycle implication
`define SRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srt assertion failed");

`endif

/* hdl/srt_pkg.sv */
`default_nettype none

package srt_pkg;

  typedef enum logic [2:0] {
    OP_FIND   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PROT   = 3'd3,
    OP_SETFILE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;

  localparam logic REG_FILE_TYPE = 1'b0;
  localparam logic [7:0] FILE_TYPE_RESET = 8'd1;

  // top two address bytes are never mappable
  localparam logic [48:0] END_LIMIT = 49'h0_FFFF_FFFF_FFFE;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [47:0] address;
    logic [47:0] length;
    logic [7:0]  prot;
    logic [7:0]  region_type;
    logic [31:0] file_inode;
    logic [47:0] file_offset;
    logic [47:0] file_length;
    logic [31:0] file_generation;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [47:0] hit_base;
    logic [47:0] hit_length;
    logic [7:0]  hit_prot;
    logic [7:0]  hit_type;
    logic [31:0] hit_inode;
    logic [47:0] hit_offset;
    logic [47:0] hit_file_length;
    logic [31:0] hit_generation;
    logic [10:0] region_count;
  } res_t;

  typedef struct packed {
    logic [47:0] base;
    logic [47:0] length;
    logic [7:0]  prot;
    logic [7:0]  kind;
    logic [31:0] inode;
    logic [31:0] generation;
    logic [47:0] file_offset;
    logic [47:0] backing_size;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic scan_ev;
    logic decide;
    logic copy_rd;
    logic copy_ev;
    logic emit;
    logic tail;
    logic commit;
    logic respond;
  } dp_cmd_t;

  typedef struct packed {
    logic no_scan;
    logic scan_done;
    logic need_copy;
    logic copy_end;
    logic emit_done;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/srt_ram.sv */
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 272,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/srt_ctrl.sv */
`default_nettype none

module srt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire srt_pkg::dp_stat_t stat_i,
  output srt_pkg::dp_cmd_t       cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_COPY_RD, S_COPY_EV,
    S_EMIT, S_TAIL, S_EMIT_TAIL, S_COMMIT, S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_PRE;
        end
      end
      S_PRE: state_d = stat_i.no_scan ? S_RESP : S_SCAN_RD;
      S_SCAN_RD: begin
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd_o.scan_ev = 1'b1;
        state_d = S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = stat_i.need_copy ? S_COPY_RD : S_RESP;
      end
      S_COPY_RD: begin
        if (stat_i.copy_end) begin
          state_d = S_TAIL;
        end else begin
          cmd_o.copy_rd = 1'b1;
          state_d = S_COPY_EV;
        end
      end
      S_COPY_EV: begin
        cmd_o.copy_ev = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.emit_done) begin
          state_d = S_COPY_RD;
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d = S_EMIT_TAIL;
      end
      S_EMIT_TAIL: begin
        if (stat_i.emit_done) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_RESP);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hdl/srt_dpath.sv */
`default_nettype none

module srt_dpath #(
  parameter int CAPACITY = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire srt_pkg::dp_cmd_t cmd_i,
  input  wire srt_pkg::cmd_t    item_i,
  input  wire logic [7:0]       file_type_i,
  output srt_pkg::dp_stat_t     stat_o,
  output srt_pkg::res_t         res_o
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int EXW  = CNTW + 1;
  localparam int EW   = $bits(srt_pkg::entry_t);
  localparam logic [CNTW-1:0] CAP = CNTW'(CAPACITY);

  srt_pkg::cmd_t   item_q;
  srt_pkg::entry_t prev_q, next_q, hit_e_q;
  srt_pkg::entry_t emit_q [3];
  srt_pkg::res_t   res_q, res_d;
  logic [CNTW-1:0] count_q, rd_idx_q, wr_ptr_q, idx_q, hit_idx_q;
  logic [EXW-1:0]  extra_q;
  logic            active_q, have_prev_q, have_next_q, hit_q, split_q;
  logic            mp_q, mb_q, mn_q, new_q;
  logic [1:0]      status_q, emit_n_q, k_q;

  // table banks: pass two streams the active bank into the other one
  logic [EW-1:0]   rdata0, rdata1, wdata;
  logic            we0, we1, sfb_we;
  logic [IDXW-1:0] waddr;
  srt_pkg::entry_t e, sfb_e;

  srt_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_bank0 (
    .clk_i, .we_i(we0), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd_i.scan_rd | cmd_i.copy_rd), .raddr_i(rd_idx_q[IDXW-1:0]), .rdata_o(rdata0)
  );
  srt_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_bank1 (
    .clk_i, .we_i(we1), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd_i.scan_rd | cmd_i.copy_rd), .raddr_i(rd_idx_q[IDXW-1:0]), .rdata_o(rdata1)
  );

  assign e = srt_pkg::entry_t'(active_q ? rdata1 : rdata0);

  srt_pkg::op_e op;
  assign op = srt_pkg::op_e'(item_q.opcode);

  logic [48:0] a49, end49, eb, ee, pe, ne;
  assign a49   = {1'b0, item_q.address};
  assign end49 = a49 + {1'b0, item_q.length};
  assign eb    = {1'b0, e.base};
  assign ee    = eb + {1'b0, e.length};
  assign pe    = {1'b0, prev_q.base} + {1'b0, prev_q.length};
  assign ne    = {1'b0, next_q.base};

  logic len_zero, nov, covered;
  assign len_zero = (item_q.length == '0);
  assign nov      = (ee <= a49) || (eb >= end49);
  assign covered  = (eb >= a49) && (ee <= end49);

  function automatic srt_pkg::entry_t frag(srt_pkg::entry_t p, logic [48:0] nb,
                                           logic [48:0] nl, logic [7:0] pr,
                                           logic [7:0] ftc);
    srt_pkg::entry_t f;
    logic [48:0]     delta;
    f       = p;
    delta   = nb - {1'b0, p.base};
    f.base  = nb[47:0];
    f.length = nl[47:0];
    f.prot  = pr;
    f.file_offset = (p.kind == ftc) ? (p.file_offset + delta[47:0]) : '0;
    return f;
  endfunction

  // insert decision from the captured neighbors
  logic       too_big, ovl, nf, mp, mb, mn;
  logic [1:0] ins_status;
  always_comb begin
    too_big = len_zero || (end49 > srt_pkg::END_LIMIT);
    ovl = (have_prev_q && (pe > a49)) || (have_next_q && (end49 > ne));
    nf  = (item_q.region_type != file_type_i);
    mp  = nf && have_prev_q && (prev_q.prot == item_q.prot) &&
          (prev_q.kind == item_q.region_type) && (pe == a49);
    mb  = mp && have_next_q && (next_q.kind != file_type_i) &&
          (next_q.prot == item_q.prot) && (next_q.kind == item_q.region_type) &&
          (end49 == ne);
    mn  = !mp && nf && have_next_q && (next_q.prot == item_q.prot) &&
          (next_q.kind == item_q.region_type) && (end49 == ne);
    if (too_big) begin
      ins_status = srt_pkg::ST_REJECT;
    end else if (ovl) begin
      ins_status = srt_pkg::ST_OVERLAP;
    end else if (mp || mn) begin
      ins_status = srt_pkg::ST_OK;
    end else if (count_q >= CAP) begin
      ins_status = srt_pkg::ST_REJECT;
    end else begin
      ins_status = srt_pkg::ST_OK;
    end
  end

  logic       rm_rej, pr_rej;
  logic [1:0] dec_status;
  assign rm_rej = split_q && (count_q >= CAP);
  assign pr_rej = ({2'b00, count_q} + {1'b0, extra_q}) > {2'b00, CAP};
  always_comb begin
    case (op)
      srt_pkg::OP_INSERT: dec_status = ins_status;
      srt_pkg::OP_REMOVE: dec_status = rm_rej ? srt_pkg::ST_REJECT : srt_pkg::ST_OK;
      srt_pkg::OP_PROT:   dec_status = pr_rej ? srt_pkg::ST_REJECT : srt_pkg::ST_OK;
      default:            dec_status = srt_pkg::ST_OK;
    endcase
  end

  srt_pkg::entry_t new_e;
  always_comb begin
    new_e        = '0;
    new_e.base   = item_q.address;
    new_e.length = item_q.length;
    new_e.prot   = item_q.prot;
    new_e.kind   = item_q.region_type;
  end

  // fragments written back for the entry just read in pass two
  srt_pkg::entry_t em0, em1, em2;
  logic [1:0]      emn;
  logic [48:0]     d_front, d_keep, d_tail, d_mid;
  always_comb begin
    em0 = e;
    em1 = e;
    em2 = e;
    emn = 2'd1;
    d_front = end49 - eb;
    d_keep  = a49 - eb;
    d_tail  = ee - end49;
    d_mid   = end49 - eb;
    case (op)
      srt_pkg::OP_INSERT: begin
        if (mp_q && ((rd_idx_q + 1'b1) == idx_q)) begin
          em0.length = e.length + item_q.length + (mb_q ? next_q.length : 48'd0);
        end else if (rd_idx_q == idx_q) begin
          if (mb_q) begin
            emn = 2'd0;
          end else if (mn_q) begin
            em0.base   = item_q.address;
            em0.length = e.length + item_q.length;
          end else if (new_q) begin
            em0 = new_e;
            em1 = e;
            emn = 2'd2;
          end
        end
      end
      srt_pkg::OP_REMOVE: begin
        if (nov) begin
          emn = 2'd1;
        end else if (covered) begin
          emn = 2'd0;
        end else if (eb >= a49) begin
          em0.base   = end49[47:0];
          em0.length = d_tail[47:0];
          if (e.kind == file_type_i) begin
            em0.file_offset = e.file_offset + d_front[47:0];
          end
        end else if (ee <= end49) begin
          em0.length = d_keep[47:0];
        end else begin
          em0.length = d_keep[47:0];
          em1 = frag(e, end49, d_tail, e.prot, file_type_i);
          emn = 2'd2;
        end
      end
      srt_pkg::OP_PROT: begin
        if (nov || (e.prot == item_q.prot)) begin
          emn = 2'd1;
        end else if (covered) begin
          em0.prot = item_q.prot;
        end else if (eb >= a49) begin
          em0.length = d_mid[47:0];
          em0.prot   = item_q.prot;
          em1 = frag(e, end49, d_tail, e.prot, file_type_i);
          emn = 2'd2;
        end else if (ee <= end49) begin
          em0.length = d_keep[47:0];
          em1 = frag(e, a49, ee - a49, item_q.prot, file_type_i);
          emn = 2'd2;
        end else begin
          em0.length = d_keep[47:0];
          em1 = frag(e, a49, {1'b0, item_q.length}, item_q.prot, file_type_i);
          em2 = frag(e, end49, d_tail, e.prot, file_type_i);
          emn = 2'd3;
        end
      end
      default: emn = 2'd1;
    endcase
  end

  always_comb begin
    sfb_e              = hit_e_q;
    sfb_e.inode        = item_q.file_inode;
    sfb_e.file_offset  = item_q.file_offset;
    sfb_e.backing_size = item_q.file_length;
    sfb_e.generation   = item_q.file_generation;
  end

  assign sfb_we = cmd_i.decide && (op == srt_pkg::OP_SETFILE) && hit_q;
  assign waddr  = sfb_we ? hit_idx_q[IDXW-1:0] : wr_ptr_q[IDXW-1:0];
  assign wdata  = sfb_we ? EW'(sfb_e) : EW'(emit_q[k_q]);
  assign we0    = (cmd_i.emit && active_q) || (sfb_we && !active_q);
  assign we1    = (cmd_i.emit && !active_q) || (sfb_we && active_q);

  always_comb begin
    res_d        = '0;
    res_d.status = status_q;
    if (((op == srt_pkg::OP_FIND) || (op == srt_pkg::OP_SETFILE)) && hit_q) begin
      res_d.found           = 1'b1;
      res_d.hit_base        = hit_e_q.base;
      res_d.hit_length      = hit_e_q.length;
      res_d.hit_prot        = hit_e_q.prot;
      res_d.hit_type        = hit_e_q.kind;
      res_d.hit_inode       = hit_e_q.inode;
      res_d.hit_offset      = hit_e_q.file_offset;
      res_d.hit_file_length = hit_e_q.backing_size;
      res_d.hit_generation  = hit_e_q.generation;
    end
    if (op == srt_pkg::OP_CLEAR) begin
      res_d.region_count = '0;
    end else begin
      res_d.region_count = 11'(count_q);
    end
  end

  // per-step state: prescan of the entry just read, copy, emit, commit and clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= 1'b0;
      rd_idx_q <= '0;
      wr_ptr_q <= '0;
      hit_q    <= 1'b0;
      k_q      <= '0;
      emit_n_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        rd_idx_q <= '0;
        hit_q    <= 1'b0;
      end
      if (cmd_i.scan_ev) begin
        rd_idx_q <= rd_idx_q + 1'b1;
        case (op)
          srt_pkg::OP_FIND: begin
            if (!hit_q && (a49 >= eb) && (a49 < ee)) begin
              hit_q <= 1'b1;
            end
          end
          srt_pkg::OP_SETFILE: begin
            if (!hit_q && (e.base == item_q.address)) begin
              hit_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.decide) begin
        rd_idx_q <= '0;
        wr_ptr_q <= '0;
      end
      if (cmd_i.copy_ev) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmd_i.copy_ev || cmd_i.tail) begin
        k_q      <= '0;
        emit_n_q <= cmd_i.tail ? ((new_q && (idx_q == count_q)) ? 2'd1 : 2'd0) : emn;
      end
      if (cmd_i.emit) begin
        k_q      <= k_q + 1'b1;
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (cmd_i.commit) begin
        active_q <= !active_q;
        count_q  <= wr_ptr_q;
      end
      if (cmd_i.respond && (op == srt_pkg::OP_CLEAR)) begin
        count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q      <= item_i;
      have_prev_q <= 1'b0;
      have_next_q <= 1'b0;
      idx_q       <= '0;
      split_q     <= 1'b0;
      extra_q     <= '0;
      status_q    <= srt_pkg::ST_OK;
      mp_q        <= 1'b0;
      mb_q        <= 1'b0;
      mn_q        <= 1'b0;
      new_q       <= 1'b0;
    end
    if (cmd_i.scan_ev) begin
      case (op)
        srt_pkg::OP_FIND: begin
          if (!hit_q && (a49 >= eb) && (a49 < ee)) begin
            hit_e_q <= e;
          end
        end
        srt_pkg::OP_SETFILE: begin
          if (!hit_q && (e.base == item_q.address)) begin
            hit_e_q   <= e;
            hit_idx_q <= rd_idx_q;
          end
        end
        srt_pkg::OP_INSERT: begin
          if (eb < a49) begin
            prev_q      <= e;
            have_prev_q <= 1'b1;
            idx_q       <= idx_q + 1'b1;
          end else if (!have_next_q) begin
            next_q      <= e;
            have_next_q <= 1'b1;
          end
        end
        srt_pkg::OP_REMOVE: begin
          if ((eb < a49) && (ee > end49)) begin
            split_q <= 1'b1;
          end
        end
        srt_pkg::OP_PROT: begin
          if (!nov && (e.prot != item_q.prot) && !covered) begin
            extra_q <= extra_q + (((eb < a49) && (ee > end49)) ? EXW'(2) : EXW'(1));
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.decide) begin
      status_q <= dec_status;
      mp_q     <= mp;
      mb_q     <= mb;
      mn_q     <= mn;
      new_q    <= (op == srt_pkg::OP_INSERT) && (ins_status == srt_pkg::ST_OK) && !mp && !mn;
      if (sfb_we) begin
        hit_e_q <= sfb_e;
      end
    end
    if (cmd_i.copy_ev) begin
      emit_q[0] <= em0;
      emit_q[1] <= em1;
      emit_q[2] <= em2;
    end
    if (cmd_i.tail) begin
      emit_q[0] <= new_e;
    end
    if (cmd_i.respond) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    stat_o.no_scan = (op == srt_pkg::OP_CLEAR) ||
                     ((op != srt_pkg::OP_FIND) && (op != srt_pkg::OP_INSERT) &&
                      (op != srt_pkg::OP_REMOVE) && (op != srt_pkg::OP_PROT) &&
                      (op != srt_pkg::OP_SETFILE)) ||
                     (((op == srt_pkg::OP_REMOVE) || (op == srt_pkg::OP_PROT)) && len_zero);
    stat_o.scan_done = (rd_idx_q == count_q) || hit_q;
    stat_o.need_copy = (dec_status == srt_pkg::ST_OK) &&
                       ((op == srt_pkg::OP_INSERT) || (op == srt_pkg::OP_REMOVE) ||
                        (op == srt_pkg::OP_PROT));
    stat_o.copy_end  = (rd_idx_q == count_q);
    stat_o.emit_done = (k_q == emit_n_q);
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* hdl/sorted_region_table_core.sv */
// Channel   Signals                                  Transaction
// command   start_i, busy_o, cmd_i                   start_i high while busy_o low
// result    done_o, res_o                            done_o high, one cycle
// config    psel_i, penable_i, pwrite_i, paddr_i ... access phase with pready_o
//
// A command scans the table one entry at a time (one RAM read, one evaluate per entry).
// find and set-file-backing stop at the hit or at the end of the table. insert, remove
// and change-protection scan all n entries, then stream them into the other bank unless
// they are rejected or overlap. clear, no-op and zero-length remove and change-protection
// commands skip the scan. done_o comes in the first idle cycle. Reset clears the count
// and the config, not the RAM banks.
`default_nettype none

module sorted_region_table_core #(
  parameter int CAPACITY = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire srt_pkg::cmd_t cmd_i,
  output logic               busy_o,
  output logic               done_o,
  output srt_pkg::res_t      res_o,
  input  wire logic          psel_i,
  input  wire logic          penable_i,
  input  wire logic          pwrite_i,
  input  wire logic [2:0]    paddr_i,
  input  wire logic [31:0]   pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  logic [7:0]        file_type_q;
  srt_pkg::dp_cmd_t  dp_cmd;
  srt_pkg::dp_stat_t dp_stat;

  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_type_q <= srt_pkg::FILE_TYPE_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 (paddr_i[2] == srt_pkg::REG_FILE_TYPE)) begin
      file_type_q <= pwdata_i[7:0];
    end
  end

  assign prdata_o = (paddr_i[2] == srt_pkg::REG_FILE_TYPE) ? {24'd0, file_type_q} : 32'd0;

  srt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .stat_i(dp_stat), .cmd_o(dp_cmd), .busy_o, .done_o
  );

  srt_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .item_i(cmd_i), .file_type_i(file_type_q),
    .stat_o(dp_stat), .res_o
  );

`include "sorted_region_table_core_assert.svh"

  `SRT_ASSERT_IMPL(a_done_idle, done_o, !busy_o)
  `SRT_ASSERT_NEXT(a_done_pulse, done_o, !done_o)
  `SRT_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `SRT_ASSERT_IMPL(a_status_code, done_o, res_o.status <= srt_pkg::ST_OVERLAP)

endmodule

`default_nettype wire
